FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared implication checks for the frame classifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/ekfc_pkg.sv
// ----------------------------------------------------------------------------
// ekfc_pkg
// Types, constants and helper functions of the EAPOL-Key frame classifier.
// ----------------------------------------------------------------------------
package ekfc_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [15:0] ETHERTYPE_RST = 16'h888E;
	localparam logic [7:0]  PKT_TYPE_RST  = 8'h03;

	localparam logic [5:0] BASE_HDR   = 6'd24;
	localparam logic [5:0] ADDR4_EXT  = 6'd6;
	localparam logic [5:0] QOS_EXT    = 6'd2;
	localparam logic [1:0] TYPE_DATA  = 2'd2;

	// BSSID field offsets within the MAC header.
	localparam logic [4:0] OFS_ADDR1 = 5'd4;
	localparam logic [4:0] OFS_ADDR2 = 5'd10;
	localparam logic [4:0] OFS_ADDR3 = 5'd16;

	// Offsets relative to the end of the MAC header.
	localparam logic [4:0] REL_SNAP_LAST = 5'd5;
	localparam logic [4:0] REL_ETH_HI    = 5'd6;
	localparam logic [4:0] REL_ETH_LO    = 5'd7;
	localparam logic [4:0] REL_PKT_TYPE  = 5'd9;
	localparam logic [4:0] REL_KI_HI     = 5'd13;
	localparam logic [4:0] REL_KI_LO     = 5'd14;

	localparam logic [15:0] KI_PAIRWISE = 16'h0008;
	localparam logic [15:0] KI_INSTALL  = 16'h0040;
	localparam logic [15:0] KI_ACK      = 16'h0080;
	localparam logic [15:0] KI_MIC      = 16'h0100;
	localparam logic [15:0] KI_SECURE   = 16'h0200;

	localparam logic [2:0] MSG_NONE = 3'd0;
	localparam logic [2:0] MSG_M1   = 3'd1;
	localparam logic [2:0] MSG_M2   = 3'd2;
	localparam logic [2:0] MSG_M3   = 3'd3;
	localparam logic [2:0] MSG_M4   = 3'd4;

	typedef enum logic {
		REG_ETHERTYPE = 1'b0,
		REG_PKT_TYPE  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] eapol_ethertype;
		logic [7:0]  key_packet_type;
	} cfg_t;

	typedef struct packed {
		logic        is_key_frame;
		logic [2:0]  handshake_msg;
		logic [47:0] bssid;
	} result_t;

	// LLC/SNAP header AA AA 03 00 00 00.
	function automatic logic [7:0] snap_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'hAA;
			3'd1: b = 8'hAA;
			3'd2: b = 8'h03;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] classify_msg(input logic [15:0] ki);
		logic inst, ack, mic, sec;
		logic [2:0] m;
		inst = |(ki & KI_INSTALL);
		ack  = |(ki & KI_ACK);
		mic  = |(ki & KI_MIC);
		sec  = |(ki & KI_SECURE);
		m    = MSG_NONE;
		if (|(ki & KI_PAIRWISE)) begin
			if (ack && !mic && !inst)
				m = MSG_M1;
			else if (ack && mic && inst)
				m = MSG_M3;
			else if (mic && !ack && !inst && !sec)
				m = MSG_M2;
			else if (mic && !ack && !inst && sec)
				m = MSG_M4;
		end
		return m;
	endfunction

endpackage

FILE: rtl/ekfc_byte_if.sv
// ----------------------------------------------------------------------------
// ekfc_byte_if
// Valid/ready channel carrying one MPDU byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface ekfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

FILE: rtl/ekfc_result_if.sv
// ----------------------------------------------------------------------------
// ekfc_result_if
// Valid/ready channel carrying one frame classification.
// ----------------------------------------------------------------------------
interface ekfc_result_if;
	logic        valid;
	logic        ready;
	logic        is_key_frame;
	logic [2:0]  handshake_msg;
	logic [47:0] bssid;

	modport source (output valid, output is_key_frame, output handshake_msg,
		output bssid, input ready);
	modport sink (input valid, input is_key_frame, input handshake_msg,
		input bssid, output ready);
endinterface

FILE: rtl/eapol_key_frame_classifier.sv
// ----------------------------------------------------------------------------
// eapol_key_frame_classifier
// Classifies 802.11 data frames carrying EAPOL-Key messages, one byte a cycle unless a last byte waits.
// ----------------------------------------------------------------------------
// A last byte is registered in the input stage; once the result register is free it
// is parsed and its result registered there, and presented from then on until taken.
// Throughput: one byte per cycle, except while a last byte waits for the previous result to be taken.
// Input bytes keep flowing while a result waits, up to the next last byte.
// Reset (arst_n low) clears the frame state and restores the default registers.
module eapol_key_frame_classifier #(
	parameter int MAX_FRAME_BYTES = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ekfc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ekfc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ekfc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	ekfc_byte_if.sink                          frame_in,
	ekfc_result_if.source                      result_out
);

	`include "assert_macros.svh"

	ekfc_pkg::cfg_t      cfg_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                res_valid_q;
	ekfc_pkg::result_t   res_q;
	ekfc_pkg::result_t   parse_res;
	logic                out_free;
	logic                s1_go;
	logic                cfg_wr;
	ekfc_pkg::reg_idx_t  reg_idx;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = ekfc_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		case (reg_idx)
			ekfc_pkg::REG_ETHERTYPE:
				prdata = ekfc_pkg::APB_DATA_W'(cfg_q.eapol_ethertype);
			ekfc_pkg::REG_PKT_TYPE:
				prdata = ekfc_pkg::APB_DATA_W'(cfg_q.key_packet_type);
			default:
				prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eapol_ethertype <= ekfc_pkg::ETHERTYPE_RST;
			cfg_q.key_packet_type <= ekfc_pkg::PKT_TYPE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				ekfc_pkg::REG_ETHERTYPE: cfg_q.eapol_ethertype <= pwdata[15:0];
				ekfc_pkg::REG_PKT_TYPE:  cfg_q.key_packet_type <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// A byte only waits in the input stage when it ends a frame and the
	// previous result has not been taken yet.
	assign out_free       = !res_valid_q || result_out.ready;
	assign s1_go          = valid_s1 && (!end_s1 || out_free);
	assign frame_in.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.valid && frame_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			byte_s1 <= frame_in.frame_byte;
			end_s1  <= frame_in.frame_end;
		end
	end

	ekfc_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.cfg        (cfg_q),
		.result     (parse_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && end_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && end_s1)
			res_q <= parse_res;
	end

	assign result_out.valid         = res_valid_q;
	assign result_out.is_key_frame  = res_q.is_key_frame;
	assign result_out.handshake_msg = res_q.handshake_msg;
	assign result_out.bssid         = res_q.bssid;

	`ASSERT_NEXT(a_end_gives_result, clk, arst_n, s1_go && end_s1, res_valid_q)
	`ASSERT_SAME(a_reject_all_zero, clk, arst_n, res_valid_q && !res_q.is_key_frame, res_q.handshake_msg == ekfc_pkg::MSG_NONE && res_q.bssid == 48'd0)
	`ASSERT_SAME(a_msg_range, clk, arst_n, res_valid_q, res_q.handshake_msg <= ekfc_pkg::MSG_M4)
	`ASSERT_SAME(a_end_waits, clk, arst_n, valid_s1 && end_s1 && !out_free, !frame_in.ready)

endmodule

FILE: rtl/ekfc_parser.sv
// ----------------------------------------------------------------------------
// ekfc_parser
// Per-frame state and byte-position compares; gives the classification of the
// frame in the cycle its last byte is processed.
// ----------------------------------------------------------------------------
module ekfc_parser #(
	parameter int MAX_FRAME_BYTES = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        frame_byte,
	input  logic              frame_end,
	input  ekfc_pkg::cfg_t    cfg,
	output ekfc_pkg::result_t result
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_FRAME_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       fc0_q, fc1_q, eth_hi_q;
	logic [47:0]      bssid_q;
	logic             match_q;
	logic [15:0]      ki_q;

	logic [7:0]       fc0_d, fc1_d, eth_hi_d;
	logic [47:0]      bssid_d;
	logic             match_d;
	logic [15:0]      ki_d;

	logic [5:0]       hdr;
	logic [4:0]       bssid_ofs;
	logic [POS_W-1:0] rel;
	logic             past_hdr;
	logic             in_bssid;
	logic             frame_ok;

	always_comb begin
		hdr = ekfc_pkg::BASE_HDR;
		if (fc1_q[1:0] == 2'b11)
			hdr = hdr + ekfc_pkg::ADDR4_EXT;
		// QoS data subtypes add the two-byte QoS control field.
		if (fc0_q[7])
			hdr = hdr + ekfc_pkg::QOS_EXT;
	end

	always_comb begin
		case (fc1_q[1:0])
			2'b00: bssid_ofs = ekfc_pkg::OFS_ADDR3;
			2'b01: bssid_ofs = ekfc_pkg::OFS_ADDR1;
			default: bssid_ofs = ekfc_pkg::OFS_ADDR2;
		endcase
	end

	assign past_hdr = pos_q >= POS_W'(hdr);
	assign rel      = pos_q - POS_W'(hdr);
	assign in_bssid = (pos_q >= POS_W'(bssid_ofs)) &&
		(pos_q < POS_W'(bssid_ofs) + POS_W'(6));

	always_comb begin
		fc0_d    = fc0_q;
		fc1_d    = fc1_q;
		eth_hi_d = eth_hi_q;
		bssid_d  = bssid_q;
		match_d  = match_q;
		ki_d     = ki_q;
		if (pos_q == '0) begin
			fc0_d = frame_byte;
		end else if (pos_q == POS_W'(1)) begin
			fc1_d = frame_byte;
		end else begin
			if (in_bssid)
				bssid_d = {bssid_q[39:0], frame_byte};
			if (past_hdr) begin
				if (rel <= POS_W'(ekfc_pkg::REL_SNAP_LAST)) begin
					if (frame_byte != ekfc_pkg::snap_byte(rel[2:0]))
						match_d = 1'b0;
				end else if (rel == POS_W'(ekfc_pkg::REL_ETH_HI)) begin
					eth_hi_d = frame_byte;
				end else if (rel == POS_W'(ekfc_pkg::REL_ETH_LO)) begin
					if ({eth_hi_q, frame_byte} != cfg.eapol_ethertype)
						match_d = 1'b0;
				end else if (rel == POS_W'(ekfc_pkg::REL_PKT_TYPE)) begin
					if (frame_byte != cfg.key_packet_type)
						match_d = 1'b0;
				end else if (rel == POS_W'(ekfc_pkg::REL_KI_HI)) begin
					ki_d = {frame_byte, ki_q[7:0]};
				end else if (rel == POS_W'(ekfc_pkg::REL_KI_LO)) begin
					ki_d = {ki_q[15:8], frame_byte};
				end
			end
		end
	end

	// Frames shorter than two bytes leave the header length stale, but they
	// fail the position check regardless.
	assign frame_ok = match_d && (fc0_d[3:2] == ekfc_pkg::TYPE_DATA) && !fc0_d[6] &&
		(pos_q >= POS_W'(2)) &&
		(pos_q >= POS_W'(hdr) + POS_W'(ekfc_pkg::REL_KI_LO));

	always_comb begin
		result = '0;
		if (frame_ok) begin
			result.is_key_frame  = 1'b1;
			result.handshake_msg = ekfc_pkg::classify_msg(ki_d);
			result.bssid         = bssid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fc0_q    <= '0;
			fc1_q    <= '0;
			eth_hi_q <= '0;
			bssid_q  <= '0;
			match_q  <= 1'b1;
			ki_q     <= '0;
		end else if (step) begin
			if (frame_end) begin
				pos_q    <= '0;
				fc0_q    <= '0;
				fc1_q    <= '0;
				eth_hi_q <= '0;
				bssid_q  <= '0;
				match_q  <= 1'b1;
				ki_q     <= '0;
			end else begin
				if (pos_q < POS_SAT)
					pos_q <= pos_q + POS_W'(1);
				fc0_q    <= fc0_d;
				fc1_q    <= fc1_d;
				eth_hi_q <= eth_hi_d;
				bssid_q  <= bssid_d;
				match_q  <= match_d;
				ki_q     <= ki_d;
			end
		end
	end

endmodule
